// ===== src/jipd_pkg.sv =====
// shared types and constants for the joint impedance pd torque block
// depends on nothing; imported by the controller, the datapath and the top level
package jipd_pkg;

  // field widths of the stream items
  localparam int JOINT_W = 4;
  localparam int VAL_W   = 32;
  localparam int LIM_W   = 31;
  localparam int AGE_W   = 17;
  localparam int TMO_W   = 16;

  // exact product of a 32 bit gain and a 33 bit error, and the torque sum
  localparam int PROD_W = 65;
  localparam int ACC_W  = 66;

  localparam logic [AGE_W-1:0] AGE_MAX       = {AGE_W{1'b1}};
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd200;

  // register indexes on the apb port
  localparam logic REG_RUN_MODE = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  // operation codes carried in s_tuser
  typedef enum logic [1:0] {
    OP_CMD_WRITE   = 2'd0,
    OP_UPDATE      = 2'd1,
    OP_TICK        = 2'd2,
    OP_LIMIT_WRITE = 2'd3
  } jipd_op_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_SUM  = 4'b0100,
    S_OUT  = 4'b1000
  } jipd_state_t;

  // one stored joint command
  typedef struct packed {
    logic signed [VAL_W-1:0] gain_d;
    logic signed [VAL_W-1:0] gain_p;
    logic signed [VAL_W-1:0] torque_ff;
    logic signed [VAL_W-1:0] velocity;
    logic signed [VAL_W-1:0] position;
  } jipd_entry_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic mul;
    logic sum;
    logic load_out;
  } jipd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_update;
    logic out_free;
  } jipd_sts_t;

endpackage

// ===== src/jipd_ctrl.sv =====
// sequencer for joint updates: accept, multiply, sum, clamp and load output
// depends on jipd_pkg; drives the datapath through jipd_cmd_t
module jipd_ctrl
  import jipd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  jipd_sts_t sts,
  output jipd_cmd_t cmd
);

  jipd_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && sts.start_update) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // commands
  assign s_tready     = (state == S_IDLE);
  assign cmd.take     = s_tvalid && (state == S_IDLE);
  assign cmd.mul      = (state == S_MUL);
  assign cmd.sum      = (state == S_SUM);
  assign cmd.load_out = (state == S_OUT) && sts.out_free;

`ifndef ASSERT_OFF
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !sts.out_free) |=> (state == S_OUT))
    else $error("result dropped while output register was full");
  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.start_update) |=> (state == S_MUL))
    else $error("accepted update did not start the multiply");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (sts.out_free && !s_tready))
    else $error("output load outside the final step");
`endif

endmodule

// ===== src/jipd_dp.sv =====
// datapath: command and limit tables, command age, pd arithmetic, output register
// depends on jipd_pkg; sequenced by jipd_ctrl
module jipd_dp
  import jipd_pkg::*;
#(
  parameter int NUM_JOINTS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  jipd_cmd_t        cmd,
  output jipd_sts_t        sts,
  input  logic [199:0]     s_tdata,
  input  logic [1:0]       s_tuser,
  input  logic             s_tlast,
  input  logic             run_mode,
  input  logic [TMO_W-1:0] timeout_ticks,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [167:0]     m_tdata,
  output logic [1:0]       m_tuser
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

  localparam logic signed [ACC_W-1:0] TQ_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] TQ_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  // input field decode
  jipd_op_t                in_op;
  logic [JOINT_W-1:0]      in_joint;
  jipd_entry_t             in_entry;
  logic [LIM_W-1:0]        in_limit;
  logic [5:0]              joint_ext;
  logic                    joint_ok;
  logic [JW-1:0]           idx;

  assign in_op              = jipd_op_t'(s_tuser);
  assign in_joint           = s_tdata[3:0];
  assign in_entry.position  = s_tdata[35:4];
  assign in_entry.velocity  = s_tdata[67:36];
  assign in_entry.torque_ff = s_tdata[99:68];
  assign in_entry.gain_p    = s_tdata[131:100];
  assign in_entry.gain_d    = s_tdata[163:132];
  assign in_limit           = s_tdata[194:164];

  assign joint_ext = {2'b00, in_joint};
  assign joint_ok  = joint_ext < 6'(NUM_JOINTS);
  assign idx       = joint_ext[JW-1:0];

  // tables, entries without a valid bit read as zero
  jipd_entry_t            cmd_mem [NUM_JOINTS];
  logic [LIM_W-1:0]       lim_mem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0]  cmd_vld;
  logic [NUM_JOINTS-1:0]  lim_vld;
  jipd_entry_t            rd_entry;
  logic [LIM_W-1:0]       rd_limit;

  logic wr_cmd, wr_lim;
  assign wr_cmd = cmd.take && (in_op == OP_CMD_WRITE) && joint_ok;
  assign wr_lim = cmd.take && (in_op == OP_LIMIT_WRITE) && joint_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= '0;
      lim_vld <= '0;
    end else begin
      if (wr_cmd) cmd_vld[idx] <= 1'b1;
      if (wr_lim) lim_vld[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_cmd) cmd_mem[idx] <= in_entry;
    if (wr_lim) lim_mem[idx] <= in_limit;
  end

  assign rd_entry = cmd_vld[idx] ? cmd_mem[idx] : '0;
  assign rd_limit = lim_vld[idx] ? lim_mem[idx] : '0;

  // command age, saturating
  logic [AGE_W-1:0] age;

  always_ff @(posedge clk) begin
    if (rst) begin
      age <= '0;
    end else if (cmd.take) begin
      case (in_op)
        OP_CMD_WRITE: begin
          if (s_tlast) age <= '0;
        end
        OP_TICK: begin
          if (age != AGE_MAX) age <= age + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign sts.start_update = (in_op == OP_UPDATE) && joint_ok;

  // capture of the addressed entry and the two errors
  logic [JOINT_W-1:0]      j_r;
  jipd_entry_t             ent_r;
  logic [LIM_W-1:0]        lim_r;
  logic                    stale_r;
  logic signed [VAL_W:0]   err_p, err_d;

  always_ff @(posedge clk) begin
    if (cmd.take && sts.start_update) begin
      j_r     <= in_joint;
      ent_r   <= rd_entry;
      lim_r   <= rd_limit;
      stale_r <= age > {1'b0, timeout_ticks};
      err_p   <= {rd_entry.position[VAL_W-1], rd_entry.position}
               - {in_entry.position[VAL_W-1], in_entry.position};
      err_d   <= {rd_entry.velocity[VAL_W-1], rd_entry.velocity}
               - {in_entry.velocity[VAL_W-1], in_entry.velocity};
    end
  end

  // gain times error, exact
  logic signed [PROD_W-1:0] prod_p, prod_d;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_p <= ent_r.gain_p * err_p;
      prod_d <= ent_r.gain_d * err_d;
    end
  end

  // floor shift of both terms plus feedforward
  logic signed [PROD_W-1:0] term_p, term_d;
  logic signed [ACC_W-1:0]  acc;

  assign term_p = prod_p >>> FRAC_BITS;
  assign term_d = prod_d >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      acc <= {term_p[PROD_W-1], term_p} + {term_d[PROD_W-1], term_d}
           + {{(ACC_W-VAL_W){ent_r.torque_ff[VAL_W-1]}}, ent_r.torque_ff};
    end
  end

  // clamp to the joint limit, then to the 32 bit range
  logic signed [ACC_W-1:0] lim_pos, lim_neg;
  logic [VAL_W-1:0]        tq;
  logic                    tq_sat;

  assign lim_pos = {{(ACC_W-LIM_W){1'b0}}, lim_r};
  assign lim_neg = -lim_pos;

  always_comb begin
    tq     = acc[VAL_W-1:0];
    tq_sat = 1'b0;
    if (lim_r != '0 && acc > lim_pos) begin
      tq     = lim_pos[VAL_W-1:0];
      tq_sat = 1'b1;
    end else if (lim_r != '0 && acc < lim_neg) begin
      tq     = lim_neg[VAL_W-1:0];
      tq_sat = 1'b1;
    end else if (acc > TQ_MAX) begin
      tq     = TQ_MAX[VAL_W-1:0];
      tq_sat = 1'b1;
    end else if (acc < TQ_MIN) begin
      tq     = TQ_MIN[VAL_W-1:0];
      tq_sat = 1'b1;
    end
  end

  // output register
  logic [JOINT_W-1:0] o_joint;
  logic [VAL_W-1:0]   o_pos, o_vel, o_tq, o_gp, o_gd;
  logic               o_tmo, o_sat;

  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_joint <= j_r;
      if (stale_r) begin
        o_pos <= '0;
        o_vel <= '0;
        o_tq  <= '0;
        o_gp  <= '0;
        o_gd  <= '0;
        o_tmo <= 1'b1;
        o_sat <= 1'b0;
      end else if (run_mode) begin
        o_pos <= ent_r.position;
        o_vel <= ent_r.velocity;
        o_tq  <= ent_r.torque_ff;
        o_gp  <= ent_r.gain_p;
        o_gd  <= ent_r.gain_d;
        o_tmo <= 1'b0;
        o_sat <= 1'b0;
      end else begin
        o_pos <= '0;
        o_vel <= '0;
        o_tq  <= tq;
        o_gp  <= '0;
        o_gd  <= '0;
        o_tmo <= 1'b0;
        o_sat <= tq_sat;
      end
    end
  end

  assign m_tdata = {4'b0000, o_gd, o_gp, o_tq, o_vel, o_pos, o_joint};
  assign m_tuser = {o_sat, o_tmo};

`ifndef ASSERT_OFF
  a_valid_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("output valid raised without a load");
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[163:4] == '0))
    else $error("timed out result carries nonzero values");
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("timed out and saturated set together");
`endif

endmodule

// ===== src/joint_impedance_pd_torque.sv =====
// joint update: accepted and captured in the idle state, multiplied, summed, then clamped
// and loaded in the output state, which waits while the output register is full; the next
// item is taken only after the load. writes, limit writes and ticks leave the idle state unchanged
// reset is synchronous: clears table valid bits and the command age at once,
// run_mode to 0 and timeout_ticks to 200; no clearing pass
// depends on jipd_pkg, jipd_ctrl and jipd_dp; holds the apb configuration registers
module joint_impedance_pd_torque
  import jipd_pkg::*;
#(
  parameter int NUM_JOINTS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  // joint[3:0], position, velocity, torque_ff, gain_p, gain_d, limit_value, zero pad
  input  logic [199:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]   s_tuser,
  // last_of_set
  input  logic         s_tlast,
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // joint_out[3:0], out_position, out_velocity, out_torque, out_gain_p, out_gain_d, zero pad
  output logic [167:0] m_tdata,
  // timed_out, saturated
  output logic [1:0]   m_tuser,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic             run_mode;
  logic [TMO_W-1:0] timeout_ticks;
  jipd_cmd_t        cmd;
  jipd_sts_t        sts;

  // configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_RUN_MODE: run_mode      <= pwdata[0];
        REG_TIMEOUT:  timeout_ticks <= pwdata[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_RUN_MODE) ? {31'b0, run_mode}
                                             : {{(32-TMO_W){1'b0}}, timeout_ticks};

  // sequencer
  jipd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // tables and arithmetic
  jipd_dp #(
    .NUM_JOINTS (NUM_JOINTS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .run_mode      (run_mode),
    .timeout_ticks (timeout_ticks),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule

// ===== sim/joint_impedance_pd_torque_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for joint_impedance_pd_torque: directed and random joint
// commands, updates, ticks and limit writes; depends on jipd_pkg and the rtl top level
module joint_impedance_pd_torque_tb;
  import jipd_pkg::*;

  localparam int NUM_J       = 12;
  localparam int FRAC        = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = 8;
  localparam logic [2:0] ADDR_RUN_MODE = {REG_RUN_MODE, 2'b00};
  localparam logic [2:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};

  // one input transaction
  typedef struct packed {
    jipd_op_t                op;
    logic [JOINT_W-1:0]      joint;
    logic signed [VAL_W-1:0] pos;
    logic signed [VAL_W-1:0] vel;
    logic signed [VAL_W-1:0] tff;
    logic signed [VAL_W-1:0] kp;
    logic signed [VAL_W-1:0] kd;
    logic                    last;
    logic [LIM_W-1:0]        limit;
  } pd_item_t;

  // one output transaction
  typedef struct packed {
    logic [JOINT_W-1:0]      joint;
    logic signed [VAL_W-1:0] position;
    logic signed [VAL_W-1:0] velocity;
    logic signed [VAL_W-1:0] torque;
    logic signed [VAL_W-1:0] gain_p;
    logic signed [VAL_W-1:0] gain_d;
    logic                    timed_out;
    logic                    saturated;
  } pd_result_t;

  logic         clk;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [199:0] s_tdata  = '0;
  logic [1:0]   s_tuser  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [167:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         psel     = 1'b0;
  logic         penable  = 1'b0;
  logic         pwrite   = 1'b0;
  logic [2:0]   paddr    = '0;
  logic [31:0]  pwdata   = '0;
  logic [31:0]  prdata;
  logic         pready;

  // stimulus and expectation stores
  pd_item_t   pending_items[$];
  pd_result_t torque_results_due[$];
  pd_item_t   drv_item;
  int         tx_gap = 0;
  int         rx_gap = 0;
  int         hold_left = 0;
  logic       hold_used = 1'b0;
  logic       hold_go = 1'b0;
  logic       quiet = 1'b0;
  int         fail_count = 0;
  int unsigned cycle_count = 0;

  // predictor state
  jipd_entry_t        cmd_tab [NUM_J];
  logic [LIM_W-1:0]   lim_tab [NUM_J];
  logic [AGE_W-1:0]   cmd_age;
  logic               mode_reg;
  logic [TMO_W-1:0]   tmo_reg;

  joint_impedance_pd_torque #(
    .NUM_JOINTS(NUM_J),
    .FRAC_BITS (FRAC)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // input driver: next transaction once the current one is taken, random idle bursts
  always @(posedge clk) begin
    pd_item_t nxt;
    logic     send;
    send = 1'b0;
    nxt  = '0;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
      end else if (pending_items.size() != 0) begin
        nxt  = pending_items.pop_front();
        send = 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) tx_gap <= $urandom_range(1, 8);
      end
      s_tvalid <= send;
      if (send) begin
        drv_item <= nxt;
        s_tdata  <= {5'b0, nxt.limit, nxt.kd, nxt.kp, nxt.tff, nxt.vel, nxt.pos, nxt.joint};
        s_tuser  <= nxt.op;
        s_tlast  <= nxt.last;
      end
    end
  end

  // result receiver: random stall bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap   <= $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // pd torque predictor: updates the bench state and queues the expected result
  task automatic pd_torque_predict(input pd_item_t it);
    pd_result_t         r;
    jipd_entry_t        c;
    logic               in_range;
    logic signed [32:0] pos_err, vel_err;
    logic signed [64:0] pos_term, vel_term;
    logic signed [65:0] tau, lim;
    in_range = it.joint < NUM_J;
    r = '0;
    case (it.op)
      OP_CMD_WRITE: begin
        if (in_range) begin
          c.position  = it.pos;
          c.velocity  = it.vel;
          c.torque_ff = it.tff;
          c.gain_p    = it.kp;
          c.gain_d    = it.kd;
          cmd_tab[it.joint] = c;
        end
        if (it.last) cmd_age = '0;
      end
      OP_TICK: begin
        if (cmd_age != AGE_MAX) cmd_age = cmd_age + 1'b1;
      end
      OP_LIMIT_WRITE: begin
        if (in_range) lim_tab[it.joint] = it.limit;
      end
      OP_UPDATE: begin
        if (in_range) begin
          c = cmd_tab[it.joint];
          r.joint = it.joint;
          if (cmd_age > tmo_reg) begin
            // stale command zeroes every value but the joint
            r.timed_out = 1'b1;
          end else if (mode_reg) begin
            r.position = c.position;
            r.velocity = c.velocity;
            r.torque   = c.torque_ff;
            r.gain_p   = c.gain_p;
            r.gain_d   = c.gain_d;
          end else begin
            // exact errors and products, floor shift, then limit and 32 bit clamp
            pos_err  = c.position - it.pos;
            vel_err  = c.velocity - it.vel;
            pos_term = (c.gain_p * pos_err) >>> FRAC;
            vel_term = (c.gain_d * vel_err) >>> FRAC;
            tau      = pos_term + vel_term + c.torque_ff;
            lim      = {35'd0, lim_tab[it.joint]};
            if (lim != 0) begin
              if (tau > lim) begin
                tau = lim;
                r.saturated = 1'b1;
              end else if (tau < -lim) begin
                tau = -lim;
                r.saturated = 1'b1;
              end
            end
            if (tau > 66'sd2147483647) begin
              tau = 66'sd2147483647;
              r.saturated = 1'b1;
            end else if (tau < -66'sd2147483648) begin
              tau = -66'sd2147483648;
              r.saturated = 1'b1;
            end
            r.torque = tau[31:0];
          end
          torque_results_due.insert(torque_results_due.size(), r);
        end
      end
    endcase
  endtask

  // monitor: check each result transaction, predict from each input transaction
  always @(posedge clk) begin
    pd_result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.joint     = m_tdata[3:0];
        got.position  = m_tdata[35:4];
        got.velocity  = m_tdata[67:36];
        got.torque    = m_tdata[99:68];
        got.gain_p    = m_tdata[131:100];
        got.gain_d    = m_tdata[163:132];
        got.timed_out = m_tuser[0];
        got.saturated = m_tuser[1];
        if (torque_results_due.size() == 0) begin
          $error("result for joint %0d with nothing expected", got.joint);
          fail_count++;
        end else begin
          want = torque_results_due.pop_front();
          check_field("joint_out", want.joint, got.joint);
          check_field("out_position", want.position, got.position);
          check_field("out_velocity", want.velocity, got.velocity);
          check_field("out_torque", want.torque, got.torque);
          check_field("out_gain_p", want.gain_p, got.gain_p);
          check_field("out_gain_d", want.gain_d, got.gain_d);
          check_field("timed_out", want.timed_out, got.timed_out);
          check_field("saturated", want.saturated, got.saturated);
        end
      end
      if (s_tvalid && s_tready) pd_torque_predict(drv_item);
    end
  end

  // apb write with noise above the register width, then read back the masked value
  task automatic set_register(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (addr == ADDR_RUN_MODE) ? 32'h1 : 32'hffff;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= (value & mask) | ($urandom() & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_RUN_MODE) mode_reg = value[0];
    else tmo_reg = value[TMO_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    got = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    if (got !== (value & mask)) begin
      $error("register %0d readback: expected %h, got %h", addr, value & mask, got);
      fail_count++;
    end
  endtask

  // wait until every transaction is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || torque_results_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // append one transaction to the driver queue
  task automatic queue_item(input pd_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic queue_cmd(input logic [3:0] joint, input logic [31:0] pos, vel, tff,
                           kp, kd, input logic last);
    pd_item_t it;
    it = '0;
    it.op = OP_CMD_WRITE;
    it.joint = joint;
    it.pos = pos;
    it.vel = vel;
    it.tff = tff;
    it.kp = kp;
    it.kd = kd;
    it.last = last;
    queue_item(it);
  endtask

  task automatic queue_update(input logic [3:0] joint, input logic [31:0] pos, vel);
    pd_item_t it;
    it = '0;
    it.op = OP_UPDATE;
    it.joint = joint;
    it.pos = pos;
    it.vel = vel;
    queue_item(it);
  endtask

  task automatic queue_limit(input logic [3:0] joint, input logic [30:0] limit);
    pd_item_t it;
    it = '0;
    it.op = OP_LIMIT_WRITE;
    it.joint = joint;
    it.limit = limit;
    queue_item(it);
  endtask

  task automatic queue_ticks(input int n);
    pd_item_t it;
    it = '0;
    it.op = OP_TICK;
    repeat (n) queue_item(it);
  endtask

  // q16.16 values biased to extremes and small magnitudes
  function automatic logic [31:0] rand_q();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = '0;
      3, 4, 5: begin
        v = $urandom_range(0, 32'h3_ffff);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic pd_item_t rand_item(input jipd_op_t op);
    pd_item_t it;
    it.op = op;
    it.joint = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, NUM_J - 1));
    it.pos = rand_q();
    it.vel = rand_q();
    it.tff = rand_q();
    it.kp = rand_q();
    it.kd = rand_q();
    it.last = ($urandom_range(0, 5) == 0);
    case ($urandom_range(0, 4))
      0: it.limit = '0;
      1: it.limit = 31'h7fff_ffff;
      2: it.limit = 31'($urandom_range(0, 32'h7_ffff));
      default: it.limit = 31'($urandom());
    endcase
    return it;
  endfunction

  // mostly command sets followed by updates, the rest single random transactions
  task automatic queue_random(input int count);
    pd_item_t it;
    int       left, k, n;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, NUM_J);
        for (k = 0; k < n; k++) begin
          it = rand_item(OP_CMD_WRITE);
          it.joint = 4'($urandom_range(0, NUM_J - 1));
          it.last = (k == n - 1);
          queue_item(it);
        end
        left -= n;
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) queue_item(rand_item(OP_UPDATE));
        left -= n;
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: it = rand_item(OP_UPDATE);
          4, 5, 6:    it = rand_item(OP_CMD_WRITE);
          7, 8:       it = rand_item(OP_TICK);
          default:    it = rand_item(OP_LIMIT_WRITE);
        endcase
        queue_item(it);
        left--;
      end
    end
  endtask

  // run mode and timeout for each random phase
  logic mode_plan [8] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  int   tmo_plan  [8] = '{200, 5, 3, 0, 200, 20, 65535, 10};

  // test sequence
  initial begin
    int ph;
    for (int j = 0; j < NUM_J; j++) begin
      cmd_tab[j] = '0;
      lim_tab[j] = '0;
    end
    cmd_age  = '0;
    mode_reg = 1'b0;
    tmo_reg  = TIMEOUT_RESET;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty table, out of range joints, extremes, rounding, clamps
    queue_update(4'd0, 32'h7fff_ffff, 32'h8000_0000);
    queue_update(4'd12, 32'h1, 32'h1);
    queue_update(4'd15, 32'h1, 32'h1);
    queue_limit(4'd15, 31'h7fff_ffff);
    queue_cmd(4'd3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h7fff_ffff, 1'b0);
    queue_update(4'd3, 32'h8000_0000, 32'h8000_0000);
    queue_cmd(4'd4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 1'b0);
    queue_update(4'd4, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_cmd(4'd11, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000,
              32'h8000_0000, 1'b0);
    queue_update(4'd11, 32'h7fff_ffff, 32'h8000_0000);
    // floor rounding of a tiny negative product
    queue_cmd(4'd0, 32'h0, 32'h0, 32'h0, 32'h1, 32'hffff_ffff, 1'b0);
    queue_update(4'd0, 32'h1, 32'h3);
    // limit of 1.0 against a torque of +-6.0 and 0
    queue_limit(4'd5, 31'h1_0000);
    queue_cmd(4'd5, 32'h3_0000, 32'h0, 32'h0, 32'h2_0000, 32'h0, 1'b0);
    queue_update(4'd5, 32'h0, 32'h0);
    queue_update(4'd5, 32'h6_0000, 32'h0);
    queue_update(4'd5, 32'h3_0000, 32'h0);
    queue_limit(4'd3, 31'h7fff_ffff);
    queue_update(4'd3, 32'h8000_0000, 32'h8000_0000);
    // out of range write still restarts the age
    queue_cmd(4'd14, 32'h1, 32'h1, 32'h1, 32'h1, 32'h1, 1'b1);
    queue_ticks(2);
    queue_limit(4'd5, 31'h0);
    queue_update(4'd5, 32'h0, 32'h0);
    wait_idle();

    // stale command with a zero timeout
    set_register(ADDR_TIMEOUT, 32'd0);
    queue_update(4'd5, 32'h0, 32'h0);
    queue_cmd(4'd0, 32'h1234_5678, 32'h8765_4321, 32'h0001_8000, 32'h4_0000,
              32'hfffe_0000, 1'b1);
    queue_update(4'd5, 32'h0, 32'h0);
    queue_update(4'd0, 32'h1000_0000, 32'h0);
    queue_ticks(1);
    queue_update(4'd5, 32'h0, 32'h0);
    wait_idle();

    // passthrough, stale and fresh
    set_register(ADDR_RUN_MODE, 32'd1);
    queue_update(4'd5, 32'h0, 32'h0);
    queue_cmd(4'd6, 32'hdead_beef, 32'h0bad_cafe, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0001, 1'b1);
    queue_update(4'd6, 32'h0, 32'h0);
    queue_update(4'd3, 32'h0, 32'h0);
    queue_update(4'd11, 32'h0, 32'h0);
    wait_idle();

    // age reaching the timeout, crossing it, stale until the next set
    set_register(ADDR_RUN_MODE, 32'd0);
    set_register(ADDR_TIMEOUT, 32'd40);
    queue_cmd(4'd2, 32'h2_0000, 32'h0, 32'h0, 32'h1_0000, 32'h0, 1'b1);
    queue_ticks(40);
    queue_update(4'd2, 32'h0, 32'h0);
    queue_ticks(1);
    queue_update(4'd2, 32'h0, 32'h0);
    queue_ticks(5);
    queue_update(4'd2, 32'h0, 32'h0);
    queue_cmd(4'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    queue_update(4'd2, 32'h0, 32'h0);
    queue_cmd(4'd2, 32'h2_0000, 32'h0, 32'h0, 32'h1_0000, 32'h0, 1'b1);
    queue_update(4'd2, 32'h0, 32'h0);

    // random phases over several settings
    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_register(ADDR_RUN_MODE, {31'd0, mode_plan[ph]});
      set_register(ADDR_TIMEOUT, tmo_plan[ph]);
      if (ph == 5) hold_go = 1'b1;
      if (ph == 7) quiet = 1'b1;
      queue_random(183);
    end
    wait_idle();

    if (fail_count == 0 && torque_results_due.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/jipd_pkg.sv
src/jipd_ctrl.sv
src/jipd_dp.sv
src/joint_impedance_pd_torque.sv
sim/joint_impedance_pd_torque_tb.sv
